FILE: src/pbs_pkg.sv
// Package for the power button sequencer: counter width, phase and LED mode
// codes, register map and the transaction payload structs.
// No dependencies; imported by pbs_core and power_button_sequencer.
package pbs_pkg;

  localparam int unsigned COUNTER_WIDTH = 16;
  localparam int unsigned REG_IDX_WIDTH = 2;
  localparam int unsigned PADDR_WIDTH   = REG_IDX_WIDTH + 2;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;

  // Reset values of the configuration registers.
  localparam cnt_t FLASH_PERIOD_RST    = COUNTER_WIDTH'(50000);
  localparam cnt_t PRESCALE_RELOAD_RST = COUNTER_WIDTH'(50000);
  localparam cnt_t OFF_TIMEOUT_RST     = COUNTER_WIDTH'(100);

  // Register indexes (byte address divided by four).
  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_FLASH_PERIOD    = 2'd0,
    REG_PRESCALE_RELOAD = 2'd1,
    REG_OFF_TIMEOUT     = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESS    = 3'd1,
    PH_POWERED  = 3'd2,
    PH_OFFPRESS = 3'd3,
    PH_OFFWAIT  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_ON    = 2'd1,
    LED_FLASH = 2'd2
  } led_mode_e;

  // Configuration values handed to the sequencing core.
  typedef struct packed {
    cnt_t flash_period;
    cnt_t prescale_reload;
    cnt_t off_timeout;
  } pbs_cfg_t;

  typedef struct packed {
    logic tick;
    logic button_pressed;
    logic shutdown_ack;
  } pbs_in_t;

  typedef struct packed {
    logic       led_on;
    logic       relay_on;
    logic [2:0] phase;
  } pbs_out_t;

endpackage

FILE: src/pbs_core.sv
// Sequencing core: timer counters, LED and relay drive, and the phase machine.
// One sample is processed per cycle in which step_i is high.
// Depends on pbs_pkg.
module pbs_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  pbs_pkg::pbs_cfg_t  cfg_i,
  input  pbs_pkg::pbs_in_t   sample_i,
  output pbs_pkg::pbs_out_t  result_o
);
  import pbs_pkg::*;

  phase_e    phase_q, phase_d;
  led_mode_e led_mode_q, led_mode_d;
  logic      relay_mode_q, relay_mode_d;
  logic      led_pin_q, led_pin_d;
  cnt_t      flash_cnt_q, flash_cnt_d;
  cnt_t      prescale_cnt_q, prescale_cnt_d;
  cnt_t      timeout_cnt_q, timeout_cnt_d;

  // State registers advance once per accepted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      led_mode_q     <= LED_OFF;
      relay_mode_q   <= 1'b0;
      led_pin_q      <= 1'b0;
      flash_cnt_q    <= '0;
      prescale_cnt_q <= '0;
      timeout_cnt_q  <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      led_mode_q     <= led_mode_d;
      relay_mode_q   <= relay_mode_d;
      led_pin_q      <= led_pin_d;
      flash_cnt_q    <= flash_cnt_d;
      prescale_cnt_q <= prescale_cnt_d;
      timeout_cnt_q  <= timeout_cnt_d;
    end
  end

  // Timer tick, LED drive and phase update for one sample.
  always_comb begin
    phase_d        = phase_q;
    led_mode_d     = led_mode_q;
    relay_mode_d   = relay_mode_q;
    led_pin_d      = led_pin_q;
    flash_cnt_d    = flash_cnt_q;
    prescale_cnt_d = prescale_cnt_q;
    timeout_cnt_d  = timeout_cnt_q;

    // The tick counts the flash counter down to zero and runs the off timeout.
    if (sample_i.tick) begin
      if (flash_cnt_q != '0) begin
        flash_cnt_d = flash_cnt_q - cnt_t'(1);
      end
      if (timeout_cnt_q != '0) begin
        if (prescale_cnt_q != '0) begin
          prescale_cnt_d = prescale_cnt_q - cnt_t'(1);
        end else begin
          prescale_cnt_d = cfg_i.prescale_reload;
          timeout_cnt_d  = timeout_cnt_q - cnt_t'(1);
        end
      end
    end

    // LED pin follows its mode; flashing toggles when the counter runs out.
    case (led_mode_q)
      LED_ON:  led_pin_d = 1'b1;
      LED_OFF: led_pin_d = 1'b0;
      LED_FLASH: begin
        if (flash_cnt_d == '0) begin
          led_pin_d   = ~led_pin_q;
          flash_cnt_d = cfg_i.flash_period;
        end
      end
      default: led_mode_d = LED_OFF;
    endcase

    // Phase machine.
    unique case (phase_q)
      PH_IDLE: begin
        if (sample_i.button_pressed) begin
          phase_d = PH_PRESS;
        end
      end
      PH_PRESS: begin
        if (!sample_i.button_pressed) begin
          led_mode_d   = LED_ON;
          relay_mode_d = 1'b1;
          phase_d      = PH_POWERED;
        end
      end
      PH_POWERED: begin
        if (sample_i.button_pressed) begin
          led_mode_d = LED_FLASH;
          phase_d    = PH_OFFPRESS;
        end
      end
      PH_OFFPRESS: begin
        if (!sample_i.button_pressed) begin
          timeout_cnt_d = cfg_i.off_timeout;
          phase_d       = PH_OFFWAIT;
        end
      end
      PH_OFFWAIT: begin
        if (sample_i.shutdown_ack || (timeout_cnt_d == '0)) begin
          led_mode_d    = LED_OFF;
          relay_mode_d  = 1'b0;
          timeout_cnt_d = '0;
          phase_d       = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // The relay pin reflects the mode from before this sample's phase update.
  always_comb begin
    result_o.led_on   = led_pin_d;
    result_o.relay_on = relay_mode_q;
    result_o.phase    = phase_d;
  end

endmodule

FILE: src/power_button_sequencer.sv
// Power button sequencer top level: APB register file, sequencing core and
// a registered output stage with a skid entry.
// Depends on pbs_pkg and pbs_core.
//
// Usage: each input transaction is one sample (tick, button level, shutdown
// acknowledge) and yields exactly one result transaction (LED pin, relay pin,
// phase). A transaction moves on a rising edge where valid is high and stall
// is low. The result of an accepted sample is registered and appears on
// out_valid_o; one sample can be accepted every cycle while in_stall_o is low.
// The phase counters and pin state are updated in the cycle of acceptance,
// and the result is held in an output register. When the receiver stalls,
// one further result is caught in a skid register; in_stall_o rises only
// once that skid entry is full, so it is a registered signal.
// Reset clears the phase machine, counters and pins, and loads the
// registers with flash period 50000, prescale reload 50000 and off timeout
// 100. Registers sit at byte addresses 0, 4 and 8; write them while idle.
module power_button_sequencer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pbs_pkg::pbs_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pbs_pkg::pbs_out_t                   out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pbs_pkg::PADDR_WIDTH-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import pbs_pkg::*;

  pbs_cfg_t cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  logic     accept;
  pbs_out_t result;
  pbs_out_t out_q, skid_q;
  logic     out_valid_q, skid_valid_q;
  logic     out_free;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_WIDTH-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flash_period    <= FLASH_PERIOD_RST;
      cfg_q.prescale_reload <= PRESCALE_RELOAD_RST;
      cfg_q.off_timeout     <= OFF_TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FLASH_PERIOD:    cfg_q.flash_period    <= pwdata[COUNTER_WIDTH-1:0];
        REG_PRESCALE_RELOAD: cfg_q.prescale_reload <= pwdata[COUNTER_WIDTH-1:0];
        REG_OFF_TIMEOUT:     cfg_q.off_timeout     <= pwdata[COUNTER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_FLASH_PERIOD:    prdata = 32'(cfg_q.flash_period);
      REG_PRESCALE_RELOAD: prdata = 32'(cfg_q.prescale_reload);
      REG_OFF_TIMEOUT:     prdata = 32'(cfg_q.off_timeout);
      default:             prdata = '0;
    endcase
  end

  // A sample is taken whenever the skid entry is empty.
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;

  pbs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .cfg_i    (cfg_q),
    .sample_i (in_data_i),
    .result_o (result)
  );

  // The output register frees up when empty or when its transaction is taken.
  assign out_free = !out_valid_q || !out_stall_i;

  // Output and skid valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= result;
      end
    end else if (accept) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: bench/power_button_sequencer_test.sv
// Self-checking testbench for power_button_sequencer: drives sample transactions,
// predicts every result in a local model of the sequencer and compares it.
// Depends on pbs_pkg and the power_button_sequencer RTL.
module power_button_sequencer_test;
  import pbs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic     in_valid = 1'b0;
  logic     in_stall;
  pbs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pbs_out_t out_data;

  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  // Pending samples, and results predicted for samples already accepted.
  pbs_in_t  sample_q[$];
  pbs_out_t expected_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // Local copy of the sequencer state and its configuration.
  cnt_t       cfg_flash;
  cnt_t       cfg_prescale;
  cnt_t       cfg_timeout;
  logic [2:0] phase_q;
  logic [1:0] led_mode;
  logic       relay_mode;
  logic       led_pin;
  cnt_t       flash_cnt;
  cnt_t       pre_cnt;
  cnt_t       tmo_cnt;

  power_button_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk_i = ~clk_i;

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  function automatic void clear_sequencer_model();
    cfg_flash    = FLASH_PERIOD_RST;
    cfg_prescale = PRESCALE_RELOAD_RST;
    cfg_timeout  = OFF_TIMEOUT_RST;
    phase_q      = PH_IDLE;
    led_mode     = LED_OFF;
    relay_mode   = 1'b0;
    led_pin      = 1'b0;
    flash_cnt    = '0;
    pre_cnt      = '0;
    tmo_cnt      = '0;
  endfunction

  // One sample: timer tick first, then pin drive, then the phase machine.
  function automatic pbs_out_t sequence_step(input pbs_in_t s);
    pbs_out_t r;
    logic     relay_pin;
    if (s.tick) begin
      if (flash_cnt != '0) flash_cnt = flash_cnt - cnt_t'(1);
      if (tmo_cnt != '0) begin
        if (pre_cnt != '0) begin
          pre_cnt = pre_cnt - cnt_t'(1);
        end else begin
          pre_cnt = cfg_prescale;
          tmo_cnt = tmo_cnt - cnt_t'(1);
        end
      end
    end
    case (led_mode)
      LED_ON: led_pin = 1'b1;
      LED_OFF: led_pin = 1'b0;
      LED_FLASH: begin
        if (flash_cnt == '0) begin
          led_pin   = ~led_pin;
          flash_cnt = cfg_flash;
        end
      end
      default: led_mode = LED_OFF;
    endcase
    // The relay pin reflects the mode from before this sample's phase update.
    relay_pin = relay_mode;
    case (phase_q)
      PH_IDLE: begin
        if (s.button_pressed) phase_q = PH_PRESS;
      end
      PH_PRESS: begin
        if (!s.button_pressed) begin
          led_mode   = LED_ON;
          relay_mode = 1'b1;
          phase_q    = PH_POWERED;
        end
      end
      PH_POWERED: begin
        if (s.button_pressed) begin
          phase_q  = PH_OFFPRESS;
          led_mode = LED_FLASH;
        end
      end
      PH_OFFPRESS: begin
        if (!s.button_pressed) begin
          phase_q = PH_OFFWAIT;
          tmo_cnt = cfg_timeout;
        end
      end
      PH_OFFWAIT: begin
        if (s.shutdown_ack || tmo_cnt == '0) begin
          led_mode   = LED_OFF;
          relay_mode = 1'b0;
          tmo_cnt    = '0;
          phase_q    = PH_IDLE;
        end
      end
      default: phase_q = PH_IDLE;
    endcase
    r.led_on   = led_pin;
    r.relay_on = relay_pin;
    r.phase    = phase_q;
    return r;
  endfunction

  function automatic void push_sample(input bit tk, input bit btn, input bit ack);
    pbs_in_t s;
    s.tick           = tk;
    s.button_pressed = btn;
    s.shutdown_ack   = ack;
    sample_q.push_back(s);
  endfunction

  function automatic bit rand_tick();
    return $urandom_range(99) < 60;
  endfunction

  // A full on/off cycle with random timing, ticks and acknowledge noise.
  function automatic void add_power_cycle();
    repeat ($urandom_range(3)) push_sample(rand_tick(), 1'b0, 1'($urandom_range(1)));
    repeat ($urandom_range(1, 3)) push_sample(rand_tick(), 1'b1, 1'($urandom_range(1)));
    repeat ($urandom_range(1, 4)) push_sample(rand_tick(), 1'b0, 1'($urandom_range(1)));
    repeat ($urandom_range(1, 3)) push_sample(rand_tick(), 1'b1, 1'($urandom_range(1)));
    repeat ($urandom_range(1, 12)) push_sample(rand_tick(), 1'b0, $urandom_range(99) < 8);
    // Most off waits end on acknowledge; the rest rely on the timeout.
    if ($urandom_range(99) < 70) push_sample(rand_tick(), 1'b0, 1'b1);
  endfunction

  // Register write followed by a read back of the same register.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_FLASH_PERIOD: cfg_flash = value[COUNTER_WIDTH-1:0];
      REG_PRESCALE_RELOAD: cfg_prescale = value[COUNTER_WIDTH-1:0];
      default: cfg_timeout = value[COUNTER_WIDTH-1:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value[COUNTER_WIDTH-1:0])) begin
      note_failure($sformatf("register %0d read %h, expected %h", idx, prdata,
                             32'(value[COUNTER_WIDTH-1:0])));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (sample_q.size() != 0 || in_valid || expected_q.size() != 0);
  endtask

  // Driver: offer the next sample once the current one has been taken.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || !in_stall) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= sample_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on each accepted sample, check each accepted result.
  always @(posedge clk_i or negedge rst_n) begin
    pbs_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
      if (in_valid && !in_stall) begin
        expected_q.push_back(sequence_step(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("result with nothing expected: led %0b relay %0b phase %0d",
                                 out_data.led_on, out_data.relay_on, out_data.phase));
        end else begin
          want = expected_q.pop_front();
          if (out_data.led_on !== want.led_on || out_data.relay_on !== want.relay_on ||
              out_data.phase !== want.phase) begin
            note_failure($sformatf(
              "expected led %0b relay %0b phase %0d, got led %0b relay %0b phase %0d",
              want.led_on, want.relay_on, want.phase,
              out_data.led_on, out_data.relay_on, out_data.phase));
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("power_button_sequencer regression: fail");
      $finish;
    end
  end

  // Stimulus: directed walk under reset values, then randomized phases.
  initial begin
    logic [31:0] flash_set[5]    = '{32'd1, 32'd0, 32'd65535, 32'hFFFF_0002, 32'd3};
    logic [31:0] prescale_set[5] = '{32'd0, 32'd2, 32'd65535, 32'hA5A5_0001, 32'd0};
    logic [31:0] timeout_set[5]  = '{32'd0, 32'd3, 32'd65535, 32'h8000_0005, 32'd1};
    int unsigned idle_set[5]     = '{0, 59, 0, 21, 0};
    int unsigned stall_set[5]    = '{0, 0, 59, 21, 0};
    int unsigned start_len;
    clear_sequencer_model();
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed: noise in idle, power on, flash on off press, off wait ended
    // by acknowledge, then another on/off sequence whose off wait sees repeated
    // ticks before its acknowledge arrives.
    push_sample(1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 1'b1);
    push_sample(1'b1, 1'b1, 1'b0);
    push_sample(1'b0, 1'b1, 1'b1);
    push_sample(1'b1, 1'b0, 1'b0);
    push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b1, 1'b1, 1'b1);
    push_sample(1'b1, 1'b1, 1'b0);
    push_sample(1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 1'b0);
    push_sample(1'b1, 1'b1, 1'b0);
    push_sample(1'b0, 1'b0, 1'b1);
    push_sample(1'b0, 1'b1, 1'b0);
    push_sample(1'b1, 1'b0, 1'b0);
    push_sample(1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b1, 1'b0);
    push_sample(1'b1, 1'b0, 1'b0);
    push_sample(1'b0, 1'b1, 1'b0);
    push_sample(1'b1, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 1'b1);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_FLASH_PERIOD, flash_set[p]);
      write_reg(REG_PRESCALE_RELOAD, prescale_set[p]);
      write_reg(REG_OFF_TIMEOUT, timeout_set[p]);
      send_idle_pct = idle_set[p];
      stall_pct     = stall_set[p];
      @(negedge clk_i);
      start_len = 0;
      while (start_len < 100) begin
        if ($urandom_range(99) < 15) begin
          push_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
          start_len++;
        end else begin
          start_len -= sample_q.size();
          add_power_cycle();
          start_len += sample_q.size();
        end
        // Keep the pending queue short while the driver works through it.
        while (sample_q.size() > 32) @(negedge clk_i);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("power_button_sequencer regression: pass");
    end else begin
      $display("power_button_sequencer regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
src/pbs_pkg.sv
src/pbs_core.sv
src/power_button_sequencer.sv
bench/power_button_sequencer_test.sv
